/* rtl/pms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg
// Shared constants, codes and types for the point set spanning tree block.
// ----------------------------------------------------------------------------
package pms_pkg;

	localparam int MAX_POINTS = 32;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 16;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int COST_W     = 35;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_ADD     = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_EDGE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// one point on its way through the scan pipeline
	typedef struct packed {
		logic [IDX_W-1:0]          idx;
		logic [COST_W-1:0]         cost;
		logic [IDX_W-1:0]          parent;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} scan_tag_t;

endpackage

/* rtl/pms_point_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_point_store
// Coordinate memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pms_point_store import pms_pkg::*; (
	input  logic                      clk,
	input  logic                      we,
	input  logic [IDX_W-1:0]          waddr,
	input  logic signed [COORD_W-1:0] wx,
	input  logic signed [COORD_W-1:0] wy,
	input  logic [IDX_W-1:0]          raddr,
	output logic signed [COORD_W-1:0] rx,
	output logic signed [COORD_W-1:0] ry
);

	logic [2*COORD_W-1:0] mem [MAX_POINTS];
	logic [2*COORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wx, wy};
		end
		rdata_q <= mem[raddr];
	end

	assign rx = rdata_q[2*COORD_W-1:COORD_W];
	assign ry = rdata_q[COORD_W-1:0];

endmodule

/* rtl/pms_cost_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_cost_store
// Best known cost to the tree and the tree point giving it, per point.
// ----------------------------------------------------------------------------
module pms_cost_store import pms_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [COST_W-1:0] wcost,
	input  logic [IDX_W-1:0]  wparent,
	input  logic [IDX_W-1:0]  raddr,
	output logic [COST_W-1:0] rcost,
	output logic [IDX_W-1:0]  rparent
);

	logic [COST_W+IDX_W-1:0] mem [MAX_POINTS];
	logic [COST_W+IDX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wcost, wparent};
		end
		rdata_q <= mem[raddr];
	end

	assign rcost   = rdata_q[COST_W+IDX_W-1:IDX_W];
	assign rparent = rdata_q[IDX_W-1:0];

endmodule

/* rtl/pms_dist_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_dist_pipe
// Squared distance from the current tree point, three register stages.
// ----------------------------------------------------------------------------
module pms_dist_pipe import pms_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  scan_tag_t                 tag_s1,
	input  logic signed [COORD_W-1:0] kx,
	input  logic signed [COORD_W-1:0] ky,
	output logic                      valid_s4,
	output scan_tag_t                 tag_s4,
	output logic [COST_W-1:0]         sum_s4,
	output logic                      active
);

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W:0]        ndx, ndy;
	logic                    v_s2, v_s3, v_s4;
	scan_tag_t               tag_s2, tag_s3, tag_s4_q;
	logic [COORD_W-1:0]      adx_s2, ady_s2;
	logic [SQ_W-1:0]         sqx_s3, sqy_s3;
	logic [COST_W-1:0]       sum_s4_q;

	assign dx  = {tag_s1.x[COORD_W-1], tag_s1.x} - {kx[COORD_W-1], kx};
	assign dy  = {tag_s1.y[COORD_W-1], tag_s1.y} - {ky[COORD_W-1], ky};
	assign ndx = -dx;
	assign ndy = -dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= valid_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// magnitude always fits the coordinate width
		adx_s2   <= dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
		ady_s2   <= dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
		tag_s2   <= tag_s1;
		sqx_s3   <= adx_s2 * adx_s2;
		sqy_s3   <= ady_s2 * ady_s2;
		tag_s3   <= tag_s2;
		sum_s4_q <= COST_W'(sqx_s3) + COST_W'(sqy_s3);
		tag_s4_q <= tag_s3;
	end

	assign valid_s4 = v_s4;
	assign tag_s4   = tag_s4_q;
	assign sum_s4   = sum_s4_q;
	assign active   = v_s2 | v_s3 | v_s4;

endmodule

/* rtl/prim_mst_point_set.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prim_mst_point_set
// Minimum spanning tree (dense Prim) over a stored set of 2-D points.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Clear and add
// never raise busy. An add to a full store is dropped and answered in the
// next cycle by a strobe with status full. Compute with fewer than two
// points answers in the next cycle with status empty. Compute with n points
// raises busy and grows the tree from point 0, giving n-1 edge beats, the
// last one marked by last. Each edge costs one scan of the cost memory over
// points 1..n-1, one read a cycle through its read port, then a five-stage
// distance and update pipeline that drains, plus a parent coordinate read.
// Results appear on the result ports for one cycle with strobe high; the
// receiver cannot stall them. After reset the point set is empty and the
// memories hold nothing meaningful until points are added.
// ----------------------------------------------------------------------------
module prim_mst_point_set import pms_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                command,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	output logic                      strobe,
	output logic signed [COORD_W-1:0] new_x,
	output logic signed [COORD_W-1:0] new_y,
	output logic signed [COORD_W-1:0] parent_x,
	output logic signed [COORD_W-1:0] parent_y,
	output logic [1:0]                status,
	output logic                      last
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_ORG_RD  = 7'b0000010,
		S_ORG_CAP = 7'b0000100,
		S_SCAN    = 7'b0001000,
		S_DRAIN   = 7'b0010000,
		S_PAR_RD  = 7'b0100000,
		S_EMIT    = 7'b1000000
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          last_idx;
	logic [CNT_W-1:0]          edge_cnt_q;
	logic [MAX_POINTS-1:0]     in_tree_q;
	logic [IDX_W-1:0]          j_q;
	logic                      first_q;
	logic                      found_q;
	logic [IDX_W-1:0]          k_idx_q;
	logic signed [COORD_W-1:0] kx_q, ky_q;
	scan_tag_t                 best_q;

	logic                      accept;
	cmd_t                      cmd;
	logic                      issue;
	logic                      v_s1;
	logic [IDX_W-1:0]          j_s1;
	scan_tag_t                 tag_s1;
	logic                      dist_valid;

	logic                      valid_s4;
	scan_tag_t                 tag_s4;
	logic [COST_W-1:0]         sum_s4;
	logic                      dist_active;
	logic                      take;
	logic                      v_s5;
	scan_tag_t                 upd_s5;

	logic                      pt_we;
	logic [IDX_W-1:0]          pt_raddr;
	logic signed [COORD_W-1:0] pt_rx, pt_ry;
	logic [COST_W-1:0]         c_rcost;
	logic [IDX_W-1:0]          c_rparent;

	logic                      strobe_q;
	logic                      out_load;
	logic signed [COORD_W-1:0] new_x_q, new_y_q, parent_x_q, parent_y_q;
	logic [1:0]                status_q;
	logic                      last_q;

	assign accept   = start && (state_q == S_IDLE);
	assign cmd      = cmd_t'(command);
	assign busy     = (state_q != S_IDLE);
	assign last_idx = count_q - CNT_W'(1);
	assign issue    = (state_q == S_SCAN);
	assign pt_we    = accept && (cmd == CMD_ADD) && (count_q < CNT_W'(MAX_POINTS));

	always_comb begin
		case (state_q)
			S_SCAN:   pt_raddr = j_q;
			S_PAR_RD: pt_raddr = best_q.parent;
			default:  pt_raddr = '0;
		endcase
	end

	pms_point_store u_points (
		.clk   (clk),
		.we    (pt_we),
		.waddr (count_q[IDX_W-1:0]),
		.wx    (point_x),
		.wy    (point_y),
		.raddr (pt_raddr),
		.rx    (pt_rx),
		.ry    (pt_ry)
	);

	pms_cost_store u_costs (
		.clk     (clk),
		.we      (v_s5),
		.waddr   (upd_s5.idx),
		.wcost   (upd_s5.cost),
		.wparent (upd_s5.parent),
		.raddr   (j_q),
		.rcost   (c_rcost),
		.rparent (c_rparent)
	);

	// points already in the tree drop out of the scan here
	assign dist_valid = v_s1 && !in_tree_q[j_s1];
	always_comb begin
		tag_s1.idx    = j_s1;
		tag_s1.cost   = c_rcost;
		tag_s1.parent = c_rparent;
		tag_s1.x      = pt_rx;
		tag_s1.y      = pt_ry;
	end

	pms_dist_pipe u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (dist_valid),
		.tag_s1   (tag_s1),
		.kx       (kx_q),
		.ky       (ky_q),
		.valid_s4 (valid_s4),
		.tag_s4   (tag_s4),
		.sum_s4   (sum_s4),
		.active   (dist_active)
	);

	// first pass takes the distance to point 0 unconditionally
	assign take = first_q || (sum_s4 < tag_s4.cost);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			edge_cnt_q <= '0;
			in_tree_q  <= '0;
			j_q        <= '0;
			first_q    <= 1'b0;
			found_q    <= 1'b0;
			v_s1       <= 1'b0;
			v_s5       <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			v_s1     <= issue;
			v_s5     <= valid_s4;
			strobe_q <= out_load;
			if (v_s5 && (!found_q || (upd_s5.cost < best_q.cost))) begin
				found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_CLEAR: count_q <= '0;
							CMD_ADD: begin
								if (pt_we) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_COMPUTE: begin
								if (count_q >= CNT_W'(2)) begin
									in_tree_q  <= '0;
									edge_cnt_q <= '0;
									first_q    <= 1'b1;
									found_q    <= 1'b0;
									j_q        <= IDX_W'(1);
									state_q    <= S_ORG_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_ORG_RD:  state_q <= S_ORG_CAP;
				S_ORG_CAP: state_q <= S_SCAN;
				S_SCAN: begin
					if (CNT_W'(j_q) == last_idx) begin
						state_q <= S_DRAIN;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !dist_active && !v_s5) begin
						state_q <= S_PAR_RD;
					end
				end
				S_PAR_RD: begin
					in_tree_q[best_q.idx] <= 1'b1;
					edge_cnt_q            <= edge_cnt_q + CNT_W'(1);
					first_q               <= 1'b0;
					found_q               <= 1'b0;
					j_q                   <= IDX_W'(1);
					state_q               <= S_EMIT;
				end
				S_EMIT: begin
					state_q <= (edge_cnt_q == last_idx) ? S_IDLE : S_SCAN;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pipeline payload and pass bookkeeping
	always_ff @(posedge clk) begin
		j_s1          <= j_q;
		upd_s5.idx    <= tag_s4.idx;
		upd_s5.cost   <= take ? sum_s4 : tag_s4.cost;
		upd_s5.parent <= take ? k_idx_q : tag_s4.parent;
		upd_s5.x      <= tag_s4.x;
		upd_s5.y      <= tag_s4.y;
		// ascending scan with strict compare keeps the lowest index on ties
		if (v_s5 && (!found_q || (upd_s5.cost < best_q.cost))) begin
			best_q <= upd_s5;
		end
		if (state_q == S_ORG_RD) begin
			k_idx_q <= '0;
		end else if (state_q == S_ORG_CAP) begin
			kx_q <= pt_rx;
			ky_q <= pt_ry;
		end else if (state_q == S_PAR_RD) begin
			k_idx_q <= best_q.idx;
			kx_q    <= best_q.x;
			ky_q    <= best_q.y;
		end
	end

	// result beat register
	always_comb begin
		out_load = 1'b0;
		if (state_q == S_EMIT) begin
			out_load = 1'b1;
		end else if (accept && (cmd == CMD_ADD) && !pt_we) begin
			out_load = 1'b1;
		end else if (accept && (cmd == CMD_COMPUTE) && (count_q < CNT_W'(2))) begin
			out_load = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			new_x_q    <= best_q.x;
			new_y_q    <= best_q.y;
			parent_x_q <= pt_rx;
			parent_y_q <= pt_ry;
			status_q   <= ST_EDGE;
			last_q     <= (edge_cnt_q == last_idx);
		end else if (out_load) begin
			new_x_q    <= '0;
			new_y_q    <= '0;
			parent_x_q <= '0;
			parent_y_q <= '0;
			status_q   <= (cmd == CMD_ADD) ? ST_FULL : ST_EMPTY;
			last_q     <= 1'b1;
		end
	end

	assign strobe   = strobe_q;
	assign new_x    = new_x_q;
	assign new_y    = new_y_q;
	assign parent_x = parent_x_q;
	assign parent_y = parent_y_q;
	assign status   = status_q;
	assign last     = last_q;

endmodule

/* sim/pms_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_checker
// Watches the command and result channels of prim_mst_point_set. It keeps
// its own copy of the point set, grows the spanning tree itself for each
// compute beat on two or more points, and compares each result beat field
// by field with the oldest expected edge or status reply.
// ----------------------------------------------------------------------------
module pms_checker import pms_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [1:0]                command,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic                      strobe,
	input  logic signed [COORD_W-1:0] new_x,
	input  logic signed [COORD_W-1:0] new_y,
	input  logic signed [COORD_W-1:0] parent_x,
	input  logic signed [COORD_W-1:0] parent_y,
	input  logic [1:0]                status,
	input  logic                      last,
	input  logic                      run_done,
	output int                        fail_count,
	output int                        pending,
	output int                        edge_count,
	output int                        full_count,
	output int                        empty_count
);

	typedef struct packed {
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		status_t                   st;
		logic                      fin;
	} tree_beat_t;

	tree_beat_t beats_due[$];
	logic signed [COORD_W-1:0] x_mem[MAX_POINTS];
	logic signed [COORD_W-1:0] y_mem[MAX_POINTS];
	int pt_count;
	bit leftover_done;

	initial begin
		fail_count    = 0;
		pending       = 0;
		edge_count    = 0;
		full_count    = 0;
		empty_count   = 0;
		pt_count      = 0;
		leftover_done = 0;
	end

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic push_beat(input logic signed [COORD_W-1:0] nx, ny, px, py,
			input status_t st, input logic fin);
		tree_beat_t b;
		b.nx  = nx;
		b.ny  = ny;
		b.px  = px;
		b.py  = py;
		b.st  = st;
		b.fin = fin;
		beats_due.push_back(b);
		pending++;
	endtask

	function automatic bit [COST_W-1:0] sq_dist(input int a, input int b);
		longint dx, dy;
		dx = longint'(x_mem[a]) - longint'(x_mem[b]);
		dy = longint'(y_mem[a]) - longint'(y_mem[b]);
		return COST_W'(dx * dx + dy * dy);
	endfunction

	// dense prim from point 0, lowest index wins a tie
	task automatic grow_tree();
		bit [COST_W-1:0] cost[MAX_POINTS];
		int par[MAX_POINTS];
		bit joined[MAX_POINTS];
		int pick;
		bit [COST_W-1:0] c;
		for (int i = 1; i < pt_count; i++) begin
			joined[i] = 0;
			par[i]    = 0;
			cost[i]   = sq_dist(0, i);
		end
		for (int step = 1; step < pt_count; step++) begin
			pick = -1;
			for (int j = 1; j < pt_count; j++)
				if (!joined[j] && (pick < 0 || cost[j] < cost[pick]))
					pick = j;
			push_beat(x_mem[pick], y_mem[pick], x_mem[par[pick]], y_mem[par[pick]],
				ST_EDGE, step == pt_count - 1);
			joined[pick] = 1;
			// parent moves only on a strictly cheaper tree point
			for (int j = 1; j < pt_count; j++) begin
				if (joined[j])
					continue;
				c = sq_dist(pick, j);
				if (c < cost[j]) begin
					cost[j] = c;
					par[j]  = pick;
				end
			end
		end
	endtask

	task automatic take_command();
		case (cmd_t'(command))
			CMD_CLEAR: pt_count = 0;
			CMD_ADD: begin
				if (pt_count >= MAX_POINTS) begin
					push_beat('0, '0, '0, '0, ST_FULL, 1'b1);
				end else begin
					x_mem[pt_count] = point_x;
					y_mem[pt_count] = point_y;
					pt_count++;
				end
			end
			CMD_COMPUTE: begin
				if (pt_count < 2)
					push_beat('0, '0, '0, '0, ST_EMPTY, 1'b1);
				else
					grow_tree();
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [COORD_W-1:0] got,
			input logic [COORD_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 'h%h want 'h%h", name, got, want));
	endtask

	task automatic check_beat();
		tree_beat_t b;
		if (pending == 0) begin
			report_mismatch("result beat with nothing expected");
		end else begin
			b = beats_due.pop_front();
			pending--;
			check_field("new_x", new_x, b.nx);
			check_field("new_y", new_y, b.ny);
			check_field("parent_x", parent_x, b.px);
			check_field("parent_y", parent_y, b.py);
			check_field("status", COORD_W'(status), COORD_W'(b.st));
			check_field("last", COORD_W'(last), COORD_W'(b.fin));
			case (b.st)
				ST_FULL:  full_count++;
				ST_EMPTY: empty_count++;
				default:  edge_count++;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_count = 0;
		end else begin
			// a result beat always belongs to an earlier command beat
			if (strobe)
				check_beat();
			if (start && !busy)
				take_command();
			if (run_done && !leftover_done) begin
				leftover_done = 1;
				if (pending != 0)
					report_mismatch($sformatf("%0d expected beats never came", pending));
			end
		end
	end

endmodule

/* sim/prim_mst_point_set_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prim_mst_point_set_tb
// Drives clear, add and compute beats into prim_mst_point_set: a short
// directed opening (empty and one-point sets, extreme coordinates, ties,
// ignored command), then random point sets, store fills and noise with
// random gaps. The checker module predicts and compares every result beat.
// ----------------------------------------------------------------------------
module prim_mst_point_set_tb;
	import pms_pkg::*;

	localparam int LIMIT_NS     = 10_000_000;
	localparam int ITEM_TARGET  = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int SETTLE_LIMIT = 5000;

	logic clk, arst_n, start, busy, strobe, last, run_done, cmd_taken;
	logic [1:0] command, status;
	logic signed [COORD_W-1:0] point_x, point_y;
	logic signed [COORD_W-1:0] new_x, new_y, parent_x, parent_y;
	int fail_count, pending, edge_count, full_count, empty_count;
	int n_add, n_compute, n_clear, n_ignored, items;
	bit no_gaps;

	prim_mst_point_set uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.point_x  (point_x),
		.point_y  (point_y),
		.strobe   (strobe),
		.new_x    (new_x),
		.new_y    (new_y),
		.parent_x (parent_x),
		.parent_y (parent_y),
		.status   (status),
		.last     (last)
	);

	pms_checker tree_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.point_x     (point_x),
		.point_y     (point_y),
		.strobe      (strobe),
		.new_x       (new_x),
		.new_y       (new_y),
		.parent_x    (parent_x),
		.parent_y    (parent_y),
		.status      (status),
		.last        (last),
		.run_done    (run_done),
		.fail_count  (fail_count),
		.pending     (pending),
		.edge_count  (edge_count),
		.full_count  (full_count),
		.empty_count (empty_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// tells the driver at the falling edge whether the last rising edge took a beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cmd_taken <= 1'b0;
		else
			cmd_taken <= start && !busy;
	end

	task automatic idle_gap();
		int r, len;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			len = 0;
		else if (r < 85)
			len = $urandom_range(1, 3);
		else if (r < 97)
			len = $urandom_range(4, 12);
		else
			len = $urandom_range(20, 60);
		if (len > 0) begin
			start <= 1'b0;
			repeat (len) @(negedge clk);
		end
	endtask

	task automatic issue(input cmd_t cmd, input logic signed [COORD_W-1:0] x, y);
		start   <= 1'b1;
		command <= cmd;
		point_x <= x;
		point_y <= y;
		do @(negedge clk); while (!cmd_taken);
		case (cmd)
			CMD_CLEAR:   n_clear++;
			CMD_ADD:     n_add++;
			CMD_COMPUTE: n_compute++;
			default:     n_ignored++;
		endcase
		if (cmd != CMD_NONE)
			items++;
		idle_gap();
	endtask

	// full range, a tight cluster full of ties, or extreme and near-zero values
	function automatic logic signed [COORD_W-1:0] pick_coord(input int mode);
		case (mode)
			1: return COORD_W'(int'($urandom_range(0, 8)) - 4);
			2: begin
				case ($urandom_range(0, 5))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return -16'sd1;
					3: return 16'sd0;
					4: return 16'sd1;
					default: return -16'sd32767;
				endcase
			end
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic add_points(input int n, input int mode);
		repeat (n) issue(CMD_ADD, pick_coord(mode), pick_coord(mode));
	endtask

	task automatic fill_store();
		issue(CMD_CLEAR, pick_coord(0), pick_coord(0));
		add_points(MAX_POINTS + $urandom_range(1, 3), $urandom_range(0, 2));
		issue(CMD_COMPUTE, pick_coord(0), pick_coord(0));
	endtask

	initial begin
		int seq, kind, mode, n, settle;
		arst_n   = 1'b0;
		start    = 1'b0;
		command  = CMD_CLEAR;
		point_x  = '0;
		point_y  = '0;
		run_done = 1'b0;
		no_gaps  = 0;
		n_add = 0; n_compute = 0; n_clear = 0; n_ignored = 0; items = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty set, one point, then the two far corners
		issue(CMD_COMPUTE, 16'sd0, 16'sd0);
		issue(CMD_ADD, -16'sd32768, 16'sd32767);
		issue(CMD_COMPUTE, 16'sd0, 16'sd0);
		issue(CMD_ADD, 16'sd32767, -16'sd32768);
		issue(CMD_COMPUTE, 16'sd0, 16'sd0);
		issue(CMD_NONE, 16'sd5, -16'sd5);
		// a cross of equal distances from the root
		issue(CMD_CLEAR, -16'sd1, -16'sd1);
		issue(CMD_ADD, 16'sd0, 16'sd0);
		issue(CMD_ADD, 16'sd1, 16'sd0);
		issue(CMD_ADD, -16'sd1, 16'sd0);
		issue(CMD_ADD, 16'sd0, 16'sd1);
		issue(CMD_ADD, 16'sd0, -16'sd1);
		issue(CMD_ADD, 16'sd1, 16'sd0);
		issue(CMD_COMPUTE, 16'sd0, 16'sd0);
		issue(CMD_CLEAR, 16'sd0, 16'sd0);
		issue(CMD_COMPUTE, 16'sd0, 16'sd0);

		seq = 0;
		while (items < ITEM_TARGET) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			kind    = (seq == 0) ? 6 : $urandom_range(0, 9);
			mode    = $urandom_range(0, 2);
			case (kind)
				6: fill_store();
				7: repeat ($urandom_range(3, 8))
					issue(cmd_t'($urandom_range(0, 3)), pick_coord(0), pick_coord(0));
				8: begin
					// grow the current set without a clear, may run into a full store
					add_points($urandom_range(1, 6), mode);
					issue(CMD_COMPUTE, pick_coord(0), pick_coord(0));
				end
				9: begin
					issue(CMD_COMPUTE, pick_coord(0), pick_coord(0));
					issue(CMD_COMPUTE, pick_coord(0), pick_coord(0));
				end
				default: begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_POINTS)
						: $urandom_range(0, 8);
					issue(CMD_CLEAR, pick_coord(0), pick_coord(0));
					add_points(n, mode);
					issue(CMD_COMPUTE, pick_coord(0), pick_coord(0));
				end
			endcase
			seq++;
		end

		start  <= 1'b0;
		settle = 0;
		while (pending != 0 && settle < SETTLE_LIMIT) begin
			@(negedge clk);
			settle++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		run_done <= 1'b1;
		repeat (2) @(negedge clk);

		$display("run covered %0d adds, %0d computes, %0d clears, %0d ignored commands",
			n_add, n_compute, n_clear, n_ignored);
		$display("checked %0d tree edges, %0d full replies, %0d empty replies, %0d mismatches",
			edge_count, full_count, empty_count, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
rtl/pms_pkg.sv
rtl/pms_point_store.sv
rtl/pms_cost_store.sv
rtl/pms_dist_pipe.sv
rtl/prim_mst_point_set.sv
sim/pms_checker.sv
sim/prim_mst_point_set_tb.sv
